// ----- src/bbct_pkg.sv -----
package bbct_pkg;

  localparam int unsigned ADDR_BITS = 10;
  localparam int unsigned TableDepth = 1 << ADDR_BITS;

  localparam int unsigned InAddrW = 10;
  localparam int unsigned CountW = 2;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 8;

  localparam logic [CountW-1:0] CountMax = 2'd3;
  localparam logic [CountW-1:0] CountMin = 2'd0;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CfgRegMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRegInit = 2'd1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = 1;
  localparam int unsigned QCntW = 2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] idx;
    logic                 taken;
    logic                 train;
  } item_t;

  typedef struct packed {
    logic              two_bit_mode;
    logic [CountW-1:0] initial_count;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] count;
  } entry_t;

endpackage

// ----- src/bbct_front.sv -----
module bbct_front import bbct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                clearing_i,
  output logic                q_valid_o,
  output item_t               q_item_o,
  input  logic                q_pop_i
);

  item_t            fifo_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push;
  item_t            in_item;

  assign in_item.idx   = ADDR_BITS'(s_axis_tdata[InAddrW-1:0]);
  assign in_item.taken = s_axis_tdata[InAddrW];
  assign in_item.train = s_axis_tdata[InAddrW+1];

  assign s_axis_tready = (cnt_q != QCntW'(QDepth)) && !clearing_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_item_o      = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push) - QCntW'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

// ----- src/bbct_back.sv -----
module bbct_back import bbct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                q_valid_i,
  input  item_t               q_item_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e               state_q, state_d;
  logic [ADDR_BITS-1:0] clr_q, clr_d;
  item_t                item_q, item_d;
  logic                 out_valid_q, out_valid_d;
  logic [CountW-1:0]    out_count_q, out_count_d;

  entry_t               mem_q [TableDepth];
  entry_t               rd_q;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  entry_t               mem_wdata;
  logic                 mem_re;

  logic                 slot_free;
  logic                 load_out;
  logic [CountW-1:0]    cur;
  logic [CountW-1:0]    nxt;

  assign slot_free  = !out_valid_q || m_axis_tready;
  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i && slot_free;
  assign mem_re     = q_pop_o;
  assign load_out   = (state_q == ST_LOOKUP);
  assign clearing_o = (state_q == ST_CLEAR);

  assign cur = rd_q.valid ? rd_q.count : cfg_i.initial_count;

  always_comb begin
    if (!cfg_i.two_bit_mode) begin
      nxt = CountW'(item_q.taken);
    end else if (item_q.taken) begin
      nxt = (cur == CountMax) ? cur : cur + 2'd1;
    end else begin
      nxt = (cur == CountMin) ? cur : cur - 2'd1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_q.idx;
    mem_wdata = '{valid: 1'b1, count: item_q.train ? nxt : cur};
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_LOOKUP: begin
        mem_we = !rd_q.valid || item_q.train;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[q_item_i.idx];
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_count_d = out_count_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop_o) begin
          item_d  = q_item_i;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        out_valid_d = 1'b1;
        out_count_d = cur;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
      out_count_q <= out_count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_count_q);

`ifndef SYNTHESIS
  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q)
    else $error("result loaded over an untaken word");

  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from an empty queue");

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !q_pop_o && !out_valid_q)
    else $error("lookup during clearing pass");

  a_result_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> load_out)
    else $error("popped word produced no result");
`endif

endmodule

// ----- src/bimodal_branch_counter_table.sv -----
// Channel  | Direction | Payload (lowest bit first)
// s_axis   | in        | tdata: branch_address[9:0], taken, train, zero pad to 16
// m_axis   | out       | tdata: counter_value[1:0], zero pad to 8
// cfg      | in        | index 0 two_bit_mode, index 1 initial_count; data[1:0]
//
// Each word passes through the table pipeline in order: a read of the counter
// memory, then the update write and the result load. The table takes no new word
// until the last is through, as the read-modify-write of one entry makes the next read wait for the write-back.
// After reset a clearing pass over all 2^ADDR_BITS (1024) entries empties the table;
// no input word is taken during it, configuration writes are.
// A two-word queue decouples input from the table; the output register holds
// a result until taken and the table stalls only when it is still occupied.
module bimodal_branch_counter_table import bbct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // branch_address, taken, train
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // counter_value
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  clearing;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.two_bit_mode  <= 1'b1;
      cfg_q.initial_count <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgRegMode) begin
        cfg_q.two_bit_mode <= cfg_data_i[0];
      end else if (cfg_index_i == CfgRegInit) begin
        cfg_q.initial_count <= cfg_data_i[CountW-1:0];
      end
    end
  end

  bbct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .clearing_i    (clearing),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  bbct_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .clearing_o    (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
